@@ hw/rtl/sft_pkg.sv @@
package sft_pkg;

  localparam int HANDLE_W = 10;
  localparam int BUCKET_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam int SEQ_W = 224;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_HANDLE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_INET4 = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INET6 = 1'd1;

  typedef struct packed {
    logic [1:0]          action;
    logic                is_v6;
    logic [15:0]         peer_port;
    logic [63:0]         addr_hi;
    logic [63:0]         addr_lo;
    logic [63:0]         session_id;
    logic [HANDLE_W-1:0] handle_in;
  } in_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] handle_out;
    logic [BUCKET_W-1:0] bucket;
  } out_t;

  typedef struct packed {
    logic       ld_req;
    logic       clr_step;
    logic       ld_stored;
    logic       hash_step;
    logic       mod_step;
    logic       walk_ld;
    logic       walk_next;
    logic       scan_init;
    logic       scan_next;
    logic       take_slot;
    logic       ins_w1;
    logic       ins_w2;
    logic       rm_w1;
    logic       emit;
    logic [1:0] emit_st;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_insert;
    logic is_remove;
    logic hin_bad;
    logic hash_last;
    logic mod_last;
    logic tbl_full;
    logic walk_end;
    logic key_match;
    logic slot_found;
  } stat_t;

endpackage

@@ hw/rtl/session_flow_table_top.sv @@
// Session flow table: lookup, insert and remove of sessions keyed by family,
// port, address and session id in a chained hash table. A transaction is
// taken when start is high and busy is low; its single result appears on
// out_data for exactly one cycle with out_valid high, and the receiver cannot
// stall it, so it must capture every strobe. One transaction is in flight at
// a time. Per transaction: the key is hashed one byte a cycle through the
// FNV-1a multiplier, then reduced to a bucket by a reciprocal multiply and
// subtract (low half product, high half product added, quotient times
// bucket count, subtract), then the table memories are accessed. A lookup
// then walks the bucket chain entry by entry; an insert scans the valid bits
// 32 handles at a time for the lowest free one; a remove first checks its
// handle. The result strobe comes in the same cycle as busy drops. After
// reset the block clears its bucket heads and valid bits, one row a cycle,
// with busy held high; configuration writes are taken at any time.
module session_flow_table_top #(
  parameter int MAX_ENTRIES = 1024,
  parameter int BUCKETS = 1033
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  sft_pkg::in_t                   in_data,
  // result channel
  output logic                           out_valid,
  output sft_pkg::out_t                  out_data,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [sft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sft_pkg::CFG_DATA_W-1:0] cfg_data
);

  // command and status between sequencer and datapath
  sft_pkg::cmd_t  cmd;
  sft_pkg::stat_t st;

  // sequencer: walks one transaction through hash, reduce and table steps
  sft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .st    (st),
    .cmd   (cmd)
  );

  // datapath: hash unit, bucket reduction, table memories and result register
  sft_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .BUCKETS     (BUCKETS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/sft_ctrl.sv @@
module sft_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sft_pkg::stat_t st,
  output sft_pkg::cmd_t  cmd
);

  typedef enum logic [15:0] {
    S_CLEAR     = 16'h0001,
    S_IDLE      = 16'h0002,
    S_DISPATCH  = 16'h0004,
    S_RM_CHK    = 16'h0008,
    S_HASH      = 16'h0010,
    S_MOD       = 16'h0020,
    S_HEAD_WAIT = 16'h0040,
    S_WALK_LD   = 16'h0080,
    S_WALK_WAIT = 16'h0100,
    S_WALK_CHK  = 16'h0200,
    S_INS_CHK   = 16'h0400,
    S_SCAN_WAIT = 16'h0800,
    S_SCAN_CHK  = 16'h1000,
    S_INS_W1    = 16'h2000,
    S_INS_W2    = 16'h4000,
    S_RM_W1     = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.emit_st = sft_pkg::ST_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (st.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.ld_req = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = st.is_remove ? S_RM_CHK : S_HASH;
      end
      S_RM_CHK: begin
        if (st.hin_bad) begin
          cmd.emit = 1'b1;
          cmd.emit_st = sft_pkg::ST_BAD_HANDLE;
          state_nxt = S_IDLE;
        end else begin
          cmd.ld_stored = 1'b1;
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (st.hash_last) state_nxt = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (st.mod_last) state_nxt = S_HEAD_WAIT;
      end
      S_HEAD_WAIT: begin
        if (st.is_remove) state_nxt = S_RM_W1;
        else if (st.is_insert) state_nxt = S_INS_CHK;
        else state_nxt = S_WALK_LD;
      end
      S_WALK_LD: begin
        cmd.walk_ld = 1'b1;
        state_nxt = S_WALK_WAIT;
      end
      S_WALK_WAIT: begin
        state_nxt = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (st.walk_end) begin
          cmd.emit = 1'b1;
          cmd.emit_st = sft_pkg::ST_NOT_FOUND;
          state_nxt = S_IDLE;
        end else if (st.key_match) begin
          cmd.emit = 1'b1;
          cmd.emit_st = sft_pkg::ST_OK;
          state_nxt = S_IDLE;
        end else begin
          cmd.walk_next = 1'b1;
          state_nxt = S_WALK_WAIT;
        end
      end
      S_INS_CHK: begin
        if (st.tbl_full) begin
          cmd.emit = 1'b1;
          cmd.emit_st = sft_pkg::ST_FULL;
          state_nxt = S_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (st.slot_found) begin
          cmd.take_slot = 1'b1;
          state_nxt = S_INS_W1;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt = S_SCAN_WAIT;
        end
      end
      S_INS_W1: begin
        cmd.ins_w1 = 1'b1;
        state_nxt = S_INS_W2;
      end
      S_INS_W2: begin
        cmd.ins_w2 = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_st = sft_pkg::ST_OK;
        state_nxt = S_IDLE;
      end
      S_RM_W1: begin
        cmd.rm_w1 = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_st = sft_pkg::ST_OK;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/sft_datapath.sv @@
module sft_datapath #(
  parameter int MAX_ENTRIES = 1024,
  parameter int BUCKETS = 1033
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sft_pkg::in_t                     in_data,
  input  logic                             cfg_we,
  input  logic [sft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sft_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  sft_pkg::cmd_t                    cmd,
  output sft_pkg::stat_t                   st,
  output logic                             out_valid,
  output sft_pkg::out_t                    out_data
);

  localparam int LW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int BKW = $clog2(BUCKETS);
  localparam int NVW = (MAX_ENTRIES + 31) / 32;
  localparam int VAW = (NVW > 1) ? $clog2(NVW) : 1;
  localparam int CLR_N = (BUCKETS > NVW) ? BUCKETS : NVW;
  localparam int CLW = $clog2(CLR_N);
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_ENTRIES);

  // reciprocal of the bucket count, exact quotient for every 32-bit hash
  localparam int RS = 32 + BKW;
  localparam logic [63:0] RECIP = ((64'd1 << RS) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [15:0] M_LO = RECIP[15:0];
  localparam logic [16:0] M_HI = RECIP[32:16];
  localparam logic [31:0] BK32 = 32'(BUCKETS);

  typedef struct packed {
    logic        is_v6;
    logic [15:0] port;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] sid;
  } key_t;

  function automatic logic [sft_pkg::SEQ_W-1:0] build_seq(key_t k, logic [15:0] fam);
    logic [63:0] sw;
    for (int i = 0; i < 8; i++) sw[63-8*i -: 8] = k.sid[8*i +: 8];
    if (k.is_v6) build_seq = {fam[7:0], fam[15:8], k.port, k.hi, k.lo, sw};
    else build_seq = {fam[7:0], fam[15:8], k.port, k.lo[31:0], sw, 96'b0};
  endfunction

  // memories
  key_t           key_mem  [MAX_ENTRIES];
  logic [LW-1:0]  next_mem [MAX_ENTRIES];
  logic [LW-1:0]  prev_mem [MAX_ENTRIES];
  logic [LW-1:0]  head_mem [BUCKETS];
  logic [31:0]    vld_mem  [NVW];

  key_t           key_q;
  logic [LW-1:0]  next_q, prev_q, head_q;
  logic [31:0]    vword_q;

  logic [15:0]    fam4_r, fam6_r;
  logic [1:0]     act_r;
  key_t           key_r;
  logic [sft_pkg::SEQ_W-1:0] seq_r;
  logic [4:0]     nb_r, bc_r;
  logic [31:0]    h_r;
  logic [BKW-1:0] rem_r;
  logic [64:0]    prod_r;
  logic [31:0]    qb_r;
  logic [LW-1:0]  ptr_r, steps_r, cnt_r;
  logic [VAW-1:0] vaddr_r;
  logic [CLW-1:0] clr_r;
  logic           out_valid_r;
  sft_pkg::out_t  out_r;

  key_t           in_key, src_key;
  logic [15:0]    src_fam;
  logic [IW-1:0]  ptr_idx;
  logic [4:0]     bsel, slot_bit;
  logic           slot_found;
  logic [31:0]    hx;
  logic [47:0]    plo;
  logic [48:0]    phi;
  logic [31:0]    qv, qb;

  assign ptr_idx = ptr_r[IW-1:0];
  assign bsel = 5'(ptr_r);

  always_comb begin
    in_key.is_v6 = in_data.is_v6;
    in_key.port = in_data.peer_port;
    in_key.hi = in_data.is_v6 ? in_data.addr_hi : 64'd0;
    in_key.lo = in_data.is_v6 ? in_data.addr_lo : {32'd0, in_data.addr_lo[31:0]};
    in_key.sid = in_data.session_id;
    src_key = cmd.ld_stored ? key_q : in_key;
    src_fam = src_key.is_v6 ? fam6_r : fam4_r;
  end

  // lowest free slot in the fetched valid word, past-the-end bits count as taken
  always_comb begin
    slot_found = 1'b0;
    slot_bit = '0;
    for (int k = 31; k >= 0; k--) begin
      if (!vword_q[k] && (((int'(vaddr_r) << 5) + k) < MAX_ENTRIES)) begin
        slot_found = 1'b1;
        slot_bit = 5'(k);
      end
    end
  end

  assign hx = h_r ^ {24'd0, seq_r[sft_pkg::SEQ_W-1 -: 8]};

  // bucket reduction: hash times reciprocal in two halves, then subtract
  assign plo = h_r * M_LO;
  assign phi = h_r * M_HI;
  assign qv = 32'(prod_r >> RS);
  assign qb = qv * BK32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fam4_r <= 16'd2;
      fam6_r <= 16'd10;
      cnt_r <= '0;
      clr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == sft_pkg::CFG_INET4) fam4_r <= cfg_data;
      if (cfg_we && cfg_index == sft_pkg::CFG_INET6) fam6_r <= cfg_data;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      if (cmd.ins_w1) cnt_r <= cnt_r + 1'b1;
      else if (cmd.rm_w1 && cnt_r != '0) cnt_r <= cnt_r - 1'b1;
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      act_r <= in_data.action;
      ptr_r <= LW'(in_data.handle_in);
      vaddr_r <= VAW'(in_data.handle_in >> 5);
    end
    if (cmd.ld_req || cmd.ld_stored) begin
      key_r <= src_key;
      seq_r <= build_seq(src_key, src_fam);
      nb_r <= src_key.is_v6 ? 5'd28 : 5'd16;
      h_r <= sft_pkg::FNV_BASIS;
      rem_r <= '0;
      bc_r <= '0;
    end
    if (cmd.hash_step) begin
      h_r <= hx * sft_pkg::FNV_PRIME;
      seq_r <= seq_r << 8;
      nb_r <= nb_r - 1'b1;
    end
    if (cmd.mod_step) begin
      case (bc_r)
        5'd0: prod_r <= {17'd0, plo};
        5'd1: prod_r <= prod_r + {phi, 16'd0};
        5'd2: qb_r <= qb;
        default: rem_r <= BKW'(h_r - qb_r);
      endcase
      bc_r <= bc_r + 1'b1;
    end
    if (cmd.walk_ld) begin
      ptr_r <= head_q;
      steps_r <= '0;
    end
    if (cmd.walk_next) begin
      ptr_r <= next_q;
      steps_r <= steps_r + 1'b1;
    end
    if (cmd.scan_init) vaddr_r <= '0;
    if (cmd.scan_next) vaddr_r <= vaddr_r + 1'b1;
    if (cmd.take_slot) ptr_r <= LW'({vaddr_r, slot_bit});
    if (cmd.emit) begin
      out_r.status <= cmd.emit_st;
      out_r.handle_out <= (cmd.emit_st == sft_pkg::ST_OK || cmd.emit_st == sft_pkg::ST_BAD_HANDLE)
                          ? sft_pkg::HANDLE_W'(ptr_r) : '0;
      out_r.bucket <= (cmd.emit_st == sft_pkg::ST_BAD_HANDLE) ? '0 : sft_pkg::BUCKET_W'(rem_r);
    end
  end

  // key store
  always_ff @(posedge clk) begin
    if (cmd.ins_w1) key_mem[ptr_idx] <= key_r;
    key_q <= key_mem[ptr_idx];
  end

  // forward links
  always_ff @(posedge clk) begin
    if (cmd.ins_w1) next_mem[ptr_idx] <= head_q;
    else if (cmd.rm_w1 && prev_q < NULL_LINK) next_mem[prev_q[IW-1:0]] <= next_q;
    next_q <= next_mem[ptr_idx];
  end

  // backward links
  always_ff @(posedge clk) begin
    if (cmd.ins_w1 && head_q < NULL_LINK) prev_mem[head_q[IW-1:0]] <= ptr_r;
    else if (cmd.ins_w2) prev_mem[ptr_idx] <= NULL_LINK;
    else if (cmd.rm_w1 && next_q < NULL_LINK) prev_mem[next_q[IW-1:0]] <= prev_q;
    prev_q <= prev_mem[ptr_idx];
  end

  // bucket heads
  always_ff @(posedge clk) begin
    if (cmd.clr_step && int'(clr_r) < BUCKETS) head_mem[BKW'(clr_r)] <= NULL_LINK;
    else if (cmd.ins_w1) head_mem[rem_r] <= ptr_r;
    else if (cmd.rm_w1 && head_q == ptr_r) head_mem[rem_r] <= next_q;
    head_q <= head_mem[rem_r];
  end

  // valid bits, 32 per word
  always_ff @(posedge clk) begin
    if (cmd.clr_step && int'(clr_r) < NVW) vld_mem[VAW'(clr_r)] <= '0;
    else if (cmd.ins_w1) vld_mem[vaddr_r] <= vword_q | (32'd1 << bsel);
    else if (cmd.rm_w1) vld_mem[vaddr_r] <= vword_q & ~(32'd1 << bsel);
    vword_q <= vld_mem[vaddr_r];
  end

  always_comb begin
    st.clr_done = (int'(clr_r) == CLR_N - 1);
    st.is_insert = (act_r == sft_pkg::ACT_INSERT);
    st.is_remove = (act_r == sft_pkg::ACT_REMOVE);
    st.hin_bad = (ptr_r >= NULL_LINK) || !vword_q[bsel];
    st.hash_last = (nb_r == 5'd1);
    st.mod_last = (bc_r == 5'd3);
    st.tbl_full = (cnt_r >= NULL_LINK);
    st.walk_end = (ptr_r >= NULL_LINK) || (steps_r == NULL_LINK);
    st.key_match = (key_q == key_r);
    st.slot_found = slot_found;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// testbench for session_flow_table_top
// keeps its own copy of the chained hash table and predicts every response
// responses are compared field by field, in order, against the expected queue

class flow_table_scoreboard;
  localparam int SLOTS = 1024;
  localparam int NBUCKETS = 1033;
  localparam int NIL = 1024;
  localparam logic [31:0] OFFSET_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  bit                 used[SLOTS];
  bit                 fam_v6[SLOTS];
  logic [15:0]        port_of[SLOTS];
  logic [63:0]        hi_of[SLOTS];
  logic [63:0]        lo_of[SLOTS];
  logic [63:0]        sid_of[SLOTS];
  int                 next_of[SLOTS];
  int                 prev_of[SLOTS];
  int                 chain_head[NBUCKETS];
  int                 live_count;
  logic [15:0]        fam4_code;
  logic [15:0]        fam6_code;
  sft_pkg::out_t      expected_q[$];
  int                 errors;

  function new();
    for (int i = 0; i < SLOTS; i++) begin
      used[i] = 0;
    end
    for (int b = 0; b < NBUCKETS; b++) begin
      chain_head[b] = NIL;
    end
    live_count = 0;
    fam4_code = 16'd2;
    fam6_code = 16'd10;
    errors = 0;
  endfunction

  function void write_reg(logic [sft_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    if (idx == sft_pkg::CFG_INET4) begin
      fam4_code = val;
    end else begin
      fam6_code = val;
    end
  endfunction

  function logic [31:0] fold(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * HASH_PRIME;
  endfunction

  function int bucket_of(bit v6, logic [15:0] port, logic [63:0] hi, logic [63:0] lo,
                         logic [63:0] sid);
    logic [31:0] h;
    logic [15:0] fam;
    fam = v6 ? fam6_code : fam4_code;
    h = OFFSET_BASIS;
    h = fold(h, fam[7:0]);
    h = fold(h, fam[15:8]);
    h = fold(h, port[15:8]);
    h = fold(h, port[7:0]);
    if (v6) begin
      for (int i = 7; i >= 0; i--) h = fold(h, hi[8*i +: 8]);
      for (int i = 7; i >= 0; i--) h = fold(h, lo[8*i +: 8]);
    end else begin
      for (int i = 3; i >= 0; i--) h = fold(h, lo[8*i +: 8]);
    end
    for (int i = 0; i < 8; i++) h = fold(h, sid[8*i +: 8]);
    return int'(h % 32'd1033);
  endfunction

  // accepted request: update the table and queue the response it must produce
  function void note_request(sft_pkg::in_t r);
    sft_pkg::out_t e;
    logic [63:0]   hi;
    logic [63:0]   lo;
    int            b;
    int            h;
    int            slot;
    int            steps;
    hi = r.is_v6 ? r.addr_hi : 64'd0;
    lo = r.is_v6 ? r.addr_lo : {32'd0, r.addr_lo[31:0]};
    if (r.action == sft_pkg::ACT_REMOVE) begin
      h = int'(r.handle_in);
      if (!used[h]) begin
        e = '{status: sft_pkg::ST_BAD_HANDLE, handle_out: r.handle_in, bucket: '0};
      end else begin
        b = bucket_of(fam_v6[h], port_of[h], hi_of[h], lo_of[h], sid_of[h]);
        if (prev_of[h] < NIL) next_of[prev_of[h]] = next_of[h];
        if (next_of[h] < NIL) prev_of[next_of[h]] = prev_of[h];
        if (chain_head[b] == h) chain_head[b] = next_of[h];
        used[h] = 0;
        if (live_count > 0) live_count--;
        e = '{status: sft_pkg::ST_OK, handle_out: r.handle_in, bucket: b[10:0]};
      end
    end else begin
      b = bucket_of(r.is_v6, r.peer_port, hi, lo, r.session_id);
      if (r.action == sft_pkg::ACT_INSERT) begin
        slot = NIL;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!used[i]) slot = i;
        end
        if (live_count >= SLOTS || slot == NIL) begin
          e = '{status: sft_pkg::ST_FULL, handle_out: '0, bucket: b[10:0]};
        end else begin
          used[slot] = 1;
          fam_v6[slot] = r.is_v6;
          port_of[slot] = r.peer_port;
          hi_of[slot] = hi;
          lo_of[slot] = lo;
          sid_of[slot] = r.session_id;
          if (chain_head[b] < NIL) prev_of[chain_head[b]] = slot;
          next_of[slot] = chain_head[b];
          prev_of[slot] = NIL;
          chain_head[b] = slot;
          live_count++;
          e = '{status: sft_pkg::ST_OK, handle_out: slot[9:0], bucket: b[10:0]};
        end
      end else begin
        // lookup, also for the unused action code
        e = '{status: sft_pkg::ST_NOT_FOUND, handle_out: '0, bucket: b[10:0]};
        h = chain_head[b];
        steps = 0;
        while (h < NIL && steps < SLOTS) begin
          if (sid_of[h] == r.session_id && fam_v6[h] == r.is_v6 &&
              port_of[h] == r.peer_port && hi_of[h] == hi && lo_of[h] == lo) begin
            e = '{status: sft_pkg::ST_OK, handle_out: h[9:0], bucket: b[10:0]};
            break;
          end
          h = next_of[h];
          steps++;
        end
      end
    end
    expected_q.push_back(e);
  endfunction

  function void check_result(sft_pkg::out_t got);
    sft_pkg::out_t e;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected response %p", got);
      return;
    end
    e = expected_q.pop_front();
    if (got.status !== e.status || got.handle_out !== e.handle_out ||
        got.bucket !== e.bucket) begin
      errors++;
      if (errors <= 10) $display("response mismatch: expected %p, got %p", e, got);
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module testbench;
  // action code with no operation of its own
  localparam logic [1:0] ACT_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  sft_pkg::in_t  in_data;
  logic out_valid;
  sft_pkg::out_t out_data;
  logic cfg_we;
  logic [sft_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sft_pkg::CFG_DATA_W-1:0] cfg_data;

  flow_table_scoreboard sb;
  bit quiet;

  session_flow_table_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // response monitor: values read right after the edge are the ones it sampled
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_data);
    end
  end

  // one request transaction; start stays high across back-to-back transactions
  task automatic send(sft_pkg::in_t x);
    int gap;
    if (!quiet && $urandom_range(0, 39) == 0) quiet = 1;
    else if (quiet && $urandom_range(0, 29) == 0) quiet = 0;
    gap = quiet ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (busy);
    sb.note_request(x);
  endtask

  // hold off new requests until every queued response has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [sft_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic sft_pkg::in_t random_key(logic [1:0] act);
    sft_pkg::in_t x;
    x.action = act;
    x.is_v6 = 1'($urandom_range(0, 1));
    x.peer_port = 16'($urandom());
    x.addr_hi = rand64();
    x.addr_lo = rand64();
    x.session_id = rand64();
    x.handle_in = 10'($urandom());
    return x;
  endfunction

  // pick a live handle, or a random one if the table looks empty
  function automatic int live_handle();
    int h;
    for (int tries = 0; tries < 64; tries++) begin
      h = $urandom_range(0, 1023);
      if (sb.used[h]) return h;
    end
    return h;
  endfunction

  // key of a stored entry, with the bits a v4 key ignores scrambled
  function automatic sft_pkg::in_t stored_key(logic [1:0] act, int h);
    sft_pkg::in_t x;
    x = random_key(act);
    if (sb.used[h]) begin
      x.is_v6 = sb.fam_v6[h];
      x.peer_port = sb.port_of[h];
      x.session_id = sb.sid_of[h];
      if (sb.fam_v6[h]) begin
        x.addr_hi = sb.hi_of[h];
        x.addr_lo = sb.lo_of[h];
      end else begin
        x.addr_lo[31:0] = sb.lo_of[h][31:0];
      end
    end
    return x;
  endfunction

  function automatic sft_pkg::in_t mixed_item();
    sft_pkg::in_t x;
    int  r;
    logic [1:0] look;
    r = $urandom_range(0, 99);
    look = ($urandom_range(0, 9) == 0) ? ACT_SPARE : sft_pkg::ACT_LOOKUP;
    if (r < 30) begin
      x = random_key(sft_pkg::ACT_INSERT);
    end else if (r < 38) begin
      x = stored_key(sft_pkg::ACT_INSERT, live_handle());   // duplicate key
    end else if (r < 58) begin
      x = stored_key(look, live_handle());                  // should hit
    end else if (r < 63) begin
      x = stored_key(look, live_handle());
      x.is_v6 = ~x.is_v6;                                   // same bytes, other family
    end else if (r < 72) begin
      x = random_key(look);
    end else if (r < 92) begin
      x = random_key(sft_pkg::ACT_REMOVE);
      x.handle_in = 10'(live_handle());
    end else begin
      x = random_key(sft_pkg::ACT_REMOVE);                  // mostly stale handles
    end
    return x;
  endfunction

  initial begin
    sft_pkg::in_t x;
    sft_pkg::in_t k4;
    sft_pkg::in_t k6;
    sb = new();
    quiet = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register extremes; the block takes writes during its clearing pass
    write_reg(sft_pkg::CFG_INET4, 16'h0000);
    write_reg(sft_pkg::CFG_INET6, 16'hFFFF);

    // directed part
    k4 = '0;
    k6 = '{action: sft_pkg::ACT_INSERT, is_v6: 1'b1, peer_port: 16'hFFFF, addr_hi: '1,
           addr_lo: '1, session_id: '1, handle_in: '1};
    x = k4; x.action = sft_pkg::ACT_LOOKUP; send(x);   // empty table miss
    x = k4; x.action = sft_pkg::ACT_INSERT; send(x);   // handle 0
    send(x);                                           // duplicate, handle 1
    x.action = sft_pkg::ACT_LOOKUP; send(x);           // newest copy wins
    send(k6);                                          // handle 2
    x = k6; x.action = sft_pkg::ACT_LOOKUP; x.is_v6 = 1'b0; send(x); // family must match
    x.is_v6 = 1'b1; send(x);
    x.action = ACT_SPARE; send(x);                     // unused code acts as lookup
    x = random_key(sft_pkg::ACT_INSERT); x.is_v6 = 1'b0; send(x);    // handle 3
    x.action = sft_pkg::ACT_LOOKUP; x.addr_hi = ~x.addr_hi;
    x.addr_lo[63:32] = ~x.addr_lo[63:32]; send(x);     // v4 ignores upper bits
    x = '0; x.action = sft_pkg::ACT_REMOVE; x.handle_in = 10'd1; send(x);
    x = k4; x.action = sft_pkg::ACT_LOOKUP; send(x);   // older duplicate now
    x = '0; x.action = sft_pkg::ACT_REMOVE; x.handle_in = 10'd1; send(x); // already gone
    x.handle_in = 10'd1023; send(x);                   // never used
    x.handle_in = 10'd0; send(x);
    x.handle_in = 10'd2; send(x);
    x = k4; x.action = sft_pkg::ACT_LOOKUP; send(x);
    x = k6; x.action = sft_pkg::ACT_INSERT; x.session_id = '0; send(x); // reuses handle 0
    x = random_key(sft_pkg::ACT_REMOVE); x.handle_in = 10'd3; send(x);

    write_reg(sft_pkg::CFG_INET4, 16'hFFFF);
    write_reg(sft_pkg::CFG_INET6, 16'h0000);
    repeat (150) send(mixed_item());

    // fill the table to the top, then hit the full case
    write_reg(sft_pkg::CFG_INET4, 16'd2);
    write_reg(sft_pkg::CFG_INET6, 16'd10);
    while (sb.live_count < 1024) send(random_key(sft_pkg::ACT_INSERT));
    repeat (4) send(random_key(sft_pkg::ACT_INSERT));
    repeat (40) send(stored_key(sft_pkg::ACT_LOOKUP, live_handle()));
    repeat (100) send(mixed_item());

    // family codes change under a populated table
    write_reg(sft_pkg::CFG_INET4, 16'($urandom()));
    write_reg(sft_pkg::CFG_INET6, 16'($urandom()));
    repeat (100) send(mixed_item());

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
